>>> rtl/pasu_pkg.sv
`default_nettype none

package pasu_pkg;

    localparam int NUM_SOURCES_DEF = 64;
    localparam int NUM_PARAMS      = 2;

    localparam int VAL_W      = 24;
    localparam int TIME_W     = 32;
    localparam int S_DATA_W   = 152;
    localparam int S_USER_W   = 4;
    localparam int M_DATA_W   = 112;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int SRC_W      = 6;
    localparam int SRC_EXT_W  = 11;

    localparam int DIV_REM_W = 32;
    localparam int DIV_DQ_W  = 37;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        KIND_SET     = 2'd0,
        KIND_LINEAR  = 2'd1,
        KIND_SLOPE   = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    localparam logic [1:0] PARAM_VOLUME = 2'd0;
    localparam logic [1:0] PARAM_PAN    = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAMP_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFFSET    = 2'd2;

    localparam logic signed [VAL_W-1:0] SILENCE_FLOOR_RST = -24'sd5242880;
    localparam logic [30:0]             MAX_RAMP_RST      = 31'd10000;
    localparam logic [30:0]             MAX_OFFSET_RST    = 31'd1000000;
    localparam logic signed [VAL_W-1:0] PAN_MIN           = -24'sd65536;
    localparam logic signed [VAL_W-1:0] PAN_MAX           = 24'sd65536;
    localparam logic signed [VAL_W-1:0] VOLUME_MAX        = 24'sd0;

    localparam logic [DIV_DQ_W-1:0]  SLOPE_SCALE   = 37'd2000;
    localparam logic [DIV_CNT_W-1:0] INTERP_ITERS  = 6'd24;
    localparam logic [DIV_CNT_W-1:0] SLOPE_ITERS   = 6'd37;

    typedef struct packed {
        logic load;
        logic clip;
        logic fetch;
        logic div1_start;
        logic set_v1;
        logic clamp;
        logic div2_start;
        logic end_time;
        logic finish;
        logic clr;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic need_div;
        logic slope_div;
        logic div_done;
        logic out_free;
        logic clr_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/pasu_div.sv
`default_nettype none

module pasu_div
    import pasu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_REM_W-1:0] rem_init,
    input  wire logic [DIV_DQ_W-1:0]  dq_init,
    input  wire logic [DIV_REM_W-1:0] divisor,
    input  wire logic [DIV_CNT_W-1:0] iters,
    output logic                      busy,
    output logic                      done,
    output logic [DIV_DQ_W-1:0]       quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_DQ_W-1:0]  dq_reg, dq_next;
    logic [DIV_REM_W-1:0] div_reg, div_next;
    logic [DIV_REM_W:0]   rem_sh;
    logic [DIV_REM_W:0]   rem_sub;
    logic                 ge;

    // Restoring division, one quotient bit per cycle; quotient bits enter dq at the bottom.
    always_comb begin
        rem_sh  = {rem_reg, dq_reg[DIV_DQ_W-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        ge      = rem_sh >= {1'b0, div_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = rem_init;
            dq_next   = dq_init;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
            dq_next  = {dq_reg[DIV_DQ_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

>>> rtl/pasu_dp.sv
`default_nettype none

module pasu_dp
    import pasu_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic [S_USER_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    output logic                       m_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SRC_IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int IDX_W     = SRC_IDX_W + 1;
    localparam int ENTRIES   = NUM_SOURCES * NUM_PARAMS;

    // Configuration registers.
    logic signed [VAL_W-1:0] floor_reg;
    logic [30:0]             mrt_reg;
    logic [30:0]             mto_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= SILENCE_FLOOR_RST;
            mrt_reg   <= MAX_RAMP_RST;
            mto_reg   <= MAX_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SILENCE_FLOOR: floor_reg <= cfg_wdata[VAL_W-1:0];
                CFG_MAX_RAMP_TIME: mrt_reg   <= cfg_wdata;
                CFG_MAX_OFFSET:    mto_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Captured input word.
    kind_t                    kind_reg;
    logic [1:0]               param_reg;
    logic [SRC_W-1:0]         src_reg;
    logic [TIME_W-1:0]        evt_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [VAL_W-1:0]  tgt_reg;
    logic [TIME_W-1:0]        dur_reg;
    logic signed [VAL_W-1:0]  slope_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_t'(s_tuser[1:0]);
            param_reg <= s_tuser[3:2];
            src_reg   <= s_tdata[5:0];
            evt_reg   <= s_tdata[37:6];
            now_reg   <= s_tdata[69:38];
            tgt_reg   <= s_tdata[93:70];
            dur_reg   <= s_tdata[125:94];
            slope_reg <= s_tdata[149:126];
        end
    end

    logic [SRC_EXT_W-1:0] src_ext;
    logic [IDX_W-1:0]     idx;
    logic                 invalid;

    assign src_ext = {{(SRC_EXT_W-SRC_W){1'b0}}, src_reg};
    assign idx     = {src_ext[SRC_IDX_W-1:0], param_reg[0]};
    assign invalid = (param_reg != PARAM_VOLUME && param_reg != PARAM_PAN)
                  || (kind_reg == KIND_INVALID)
                  || (src_ext >= SRC_EXT_W'(NUM_SOURCES));

    // Time clip.
    logic [TIME_W-1:0] d_diff;
    logic [TIME_W-1:0] mto_ext;
    logic [TIME_W-1:0] t_clip;
    logic [TIME_W-1:0] t_reg;

    always_comb begin
        d_diff  = evt_reg - now_reg;
        mto_ext = {1'b0, mto_reg};
        if ($signed(d_diff) > $signed(mto_ext)) begin
            t_clip = now_reg + mto_ext;
        end else if ($signed(d_diff) < -$signed(mto_ext)) begin
            t_clip = now_reg - mto_ext;
        end else begin
            t_clip = evt_reg;
        end
    end

    // Segment memory: {end time, start time, end value, start value}.
    logic [M_DATA_W-1:0] mem_array [ENTRIES];
    logic [M_DATA_W-1:0] rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [M_DATA_W-1:0] mem_wdata;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [M_DATA_W-1:0] seg_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clip) begin
            rdata_reg <= mem_array[idx];
        end
        if (cmd.clip) begin
            t_reg <= t_clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Interpolation setup.
    logic signed [VAL_W-1:0] sv_old, ev_old;
    logic [TIME_W-1:0]       st_old, et_old;
    logic [TIME_W-1:0]       e_diff, span;
    logic                    e_pos, e_ge;
    logic signed [VAL_W:0]   vdiff;
    logic signed [56:0]      prod;

    logic signed [56:0]      prod_reg;
    logic [TIME_W-1:0]       span_reg;
    logic                    need_div_reg;
    logic                    e_pos_reg;
    logic signed [VAL_W-1:0] v0_reg, v1_reg;

    always_comb begin
        sv_old = rdata_reg[23:0];
        ev_old = rdata_reg[47:24];
        st_old = rdata_reg[79:48];
        et_old = rdata_reg[111:80];
        e_diff = et_old - t_reg;
        span   = et_old - st_old;
        e_pos  = !e_diff[TIME_W-1] && (e_diff != '0);
        e_ge   = $signed(e_diff) >= $signed(span);
        vdiff  = {sv_old[VAL_W-1], sv_old} - {ev_old[VAL_W-1], ev_old};
        prod   = $signed({1'b0, e_diff[30:0]}) * vdiff;
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            prod_reg     <= prod;
            span_reg     <= span;
            need_div_reg <= e_pos && !e_ge;
            e_pos_reg    <= e_pos;
            v0_reg       <= sv_old;
            v1_reg       <= ev_old;
        end
    end

    // Shared divider.
    logic                 prod_neg;
    logic [56:0]          prod_abs;
    logic                 div_start;
    logic [DIV_REM_W-1:0] div_rem_init;
    logic [DIV_DQ_W-1:0]  div_dq_init;
    logic [DIV_REM_W-1:0] div_divisor;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_DQ_W-1:0]  quot;

    logic [DIV_DQ_W-1:0]     num_reg;
    logic [VAL_W-1:0]        s_reg;
    logic                    s_zero_reg;

    assign prod_neg = prod_reg[56];
    assign prod_abs = prod_neg ? 57'(-prod_reg) : prod_reg;

    // The interpolation quotient is below 2**24, so its upper dividend bits start out in
    // the remainder and only 24 steps remain.
    always_comb begin
        div_start = cmd.div1_start || cmd.div2_start;
        if (cmd.div1_start) begin
            div_rem_init = {1'b0, prod_abs[54:24]};
            div_dq_init  = {prod_abs[23:0], 13'd0};
            div_divisor  = span_reg;
            div_iters    = INTERP_ITERS;
        end else begin
            div_rem_init = '0;
            div_dq_init  = num_reg;
            div_divisor  = {7'd0, s_reg, 1'b0};
            div_iters    = SLOPE_ITERS;
        end
    end

    pasu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .dq_init  (div_dq_init),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // New start value.
    logic [VAL_W:0]          qs;
    logic [VAL_W:0]          v1_sum;
    logic signed [VAL_W-1:0] sv_new;
    logic signed [VAL_W-1:0] sv_reg;

    always_comb begin
        qs     = prod_neg ? 25'(-{1'b0, quot[23:0]}) : {1'b0, quot[23:0]};
        v1_sum = {v1_reg[VAL_W-1], v1_reg} + qs;
        if (need_div_reg) begin
            sv_new = v1_sum[VAL_W-1:0];
        end else if (e_pos_reg) begin
            sv_new = v0_reg;
        end else begin
            sv_new = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_v1) begin
            sv_reg <= sv_new;
        end
    end

    // Clamp and slope numerator.
    logic signed [VAL_W-1:0] pmin, pmax, v2;
    logic signed [VAL_W:0]   ndiff;
    logic [VAL_W:0]          n_abs;
    logic [VAL_W-1:0]        s_abs;
    logic [DIV_DQ_W-1:0]     num;
    logic signed [VAL_W-1:0] v2_reg;

    always_comb begin
        if (param_reg == PARAM_VOLUME) begin
            pmin = floor_reg;
            pmax = VOLUME_MAX;
        end else begin
            pmin = PAN_MIN;
            pmax = PAN_MAX;
        end
        if (tgt_reg < pmin) begin
            v2 = pmin;
        end else if (tgt_reg > pmax) begin
            v2 = pmax;
        end else begin
            v2 = tgt_reg;
        end
        ndiff = {v2[VAL_W-1], v2} - {sv_reg[VAL_W-1], sv_reg};
        n_abs = ndiff[VAL_W] ? 25'(-ndiff) : ndiff;
        s_abs = slope_reg[VAL_W-1] ? 24'(-slope_reg) : slope_reg;
        num   = DIV_DQ_W'(n_abs) * SLOPE_SCALE + DIV_DQ_W'(s_abs);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clamp) begin
            v2_reg     <= v2;
            num_reg    <= num;
            s_reg      <= s_abs;
            s_zero_reg <= (s_abs == '0);
        end
    end

    // End time.
    logic [TIME_W-1:0] mrt_ext;
    logic [TIME_W-1:0] dur_cap;
    logic [30:0]       q_cap;
    logic [TIME_W-1:0] endt;
    logic [TIME_W-1:0] endt_reg;

    always_comb begin
        mrt_ext = {1'b0, mrt_reg};
        dur_cap = ($signed(dur_reg) > $signed(mrt_ext)) ? mrt_ext : dur_reg;
        q_cap   = (quot > DIV_DQ_W'(mrt_reg)) ? mrt_reg : quot[30:0];
        case (kind_reg)
            KIND_LINEAR: endt = t_reg + dur_cap;
            KIND_SLOPE: begin
                if (!s_zero_reg) begin
                    endt = t_reg + {1'b0, q_cap};
                end else if (num_reg == '0) begin
                    endt = t_reg;
                end else begin
                    endt = t_reg + mrt_ext;
                end
            end
            default: endt = t_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.end_time) begin
            endt_reg <= endt;
        end
    end

    assign seg_word = {endt_reg, t_reg, v2_reg, sv_reg};

    always_comb begin
        mem_we    = cmd.clr || (cmd.finish && !invalid);
        mem_waddr = cmd.clr ? clr_cnt_reg : idx;
        mem_wdata = cmd.clr ? '0 : seg_word;
    end

    // Output register.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.finish) begin
            out_data_reg <= invalid ? '0 : seg_word;
            out_user_reg <= invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        status.invalid   = invalid;
        status.need_div  = need_div_reg;
        status.slope_div = (kind_reg == KIND_SLOPE) && !s_zero_reg;
        status.div_done  = div_done;
        status.out_free  = !out_valid_reg || m_tready;
        status.clr_last  = (clr_cnt_reg == IDX_W'(ENTRIES - 1));
    end

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result word overwritten before it was taken");

    a_clear_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !cmd.finish && !cmd.load)
        else $error("item activity during memory clear");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> $past(div_busy))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

>>> rtl/pasu_ctrl.sv
`default_nettype none

module pasu_ctrl
    import pasu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_IDLE   = 12'b0000_0000_0010,
        ST_CLIP   = 12'b0000_0000_0100,
        ST_FETCH  = 12'b0000_0000_1000,
        ST_PREP   = 12'b0000_0001_0000,
        ST_DIV1   = 12'b0000_0010_0000,
        ST_SETV1  = 12'b0000_0100_0000,
        ST_CLAMP  = 12'b0000_1000_0000,
        ST_START2 = 12'b0001_0000_0000,
        ST_DIV2   = 12'b0010_0000_0000,
        ST_ENDT   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP: begin
                cmd.clip   = 1'b1;
                state_next = status.invalid ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (status.need_div) begin
                    cmd.div1_start = 1'b1;
                    state_next     = ST_DIV1;
                end else begin
                    state_next = ST_SETV1;
                end
            end
            ST_DIV1: begin
                if (status.div_done) begin
                    state_next = ST_SETV1;
                end
            end
            ST_SETV1: begin
                cmd.set_v1 = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_START2;
            end
            ST_START2: begin
                if (status.slope_div) begin
                    cmd.div2_start = 1'b1;
                    state_next     = ST_DIV2;
                end else begin
                    state_next = ST_ENDT;
                end
            end
            ST_DIV2: begin
                if (status.div_done) begin
                    state_next = ST_ENDT;
                end
            end
            ST_ENDT: begin
                cmd.end_time = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/param_automation_segment_unit.sv
`default_nettype none

// Linear automation segment table for per-source volume and pan. Each valid event
// word reads the stored segment, interpolates its value at the clipped event time,
// clamps the target and stores the new segment, returning one result word. An invalid
// word is not stored and returns a zero word with m_tuser set. Words are handled one
// at a time. A valid event adds a 24-step interpolation division when the old segment
// is mid-ramp, and a 37-step division for a slope ramp with a nonzero rate. Both
// divisions run on the one shared bit-serial divider, and a result may wait on
// m_tready before the next word is taken.
// After reset the block sweeps all 2*NUM_SOURCES segment entries to zero before it
// takes its first word.
module param_automation_segment_unit
    import pasu_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // source_index, event_time, current_time, target_value, ramp_duration, slope_rate
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // kind, param_select
    input  wire logic [S_USER_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // seg_start_value, seg_end_value, seg_start_time, seg_end_time
    output logic [M_DATA_W-1:0]        m_tdata,
    // status
    output logic                       m_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pasu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pasu_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire
